### hdl/khs_pkg.sv
// khs_pkg: types, constants and state codes for the k-mer hash set.
// Used by kmer_hash_set_chained and its checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package khs_pkg;

    localparam int MAX_BUCKETS_DEF = 1024;
    localparam int POOL_NODES_DEF  = 4096;
    localparam int CFG_W           = 11;
    localparam int COUNT_W         = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
    localparam int KEY_W           = 32;
    localparam int CHARS           = 16;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic        action;
        logic [63:0] front_chars;
        logic [63:0] back_chars;
    } in_word_t;

    typedef struct packed {
        logic               found;
        logic               collided;
        logic [COUNT_W-1:0] collision_total;
        logic               status;
    } out_word_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HEAD,
        S_HEADW,
        S_NODE,
        S_CMP,
        S_DONE
    } state_t;

    function automatic logic [1:0] base_digit(input logic [7:0] ch);
        logic [1:0] d;
        case (ch)
            8'h41:   d = 2'd0;
            8'h43:   d = 2'd1;
            8'h47:   d = 2'd2;
            default: d = 2'd3;
        endcase
        return d;
    endfunction

    function automatic logic [KEY_W-1:0] fragment_key(input logic [63:0] front,
                                                      input logic [63:0] back);
        logic [127:0]      all;
        logic [KEY_W-1:0]  k;
        all = {front, back};
        k = '0;
        for (int i = 0; i < CHARS; i++) begin
            k[KEY_W-1-2*i -: 2] = base_digit(all[127-8*i -: 8]);
        end
        return k;
    endfunction

endpackage
`default_nettype wire

### hdl/kmer_hash_set_chained.sv
// kmer_hash_set_chained: top level of the chained hash set of 16-base fragments.
// Depends on khs_pkg; holds the bucket and node memories and the sequencer.
//
// One word is handled at a time. After reset a clearing pass writes every bucket head
// empty, one bucket per cycle (MAX_BUCKETS buckets, 1024 by default), with in_stall high.
// The 32-bit key is then reduced modulo table_size by a restoring subtract-and-compare
// unit, one key bit per cycle. An insert then reads the bucket head and writes node and
// head. A search walks the chain: for each node visited, a registered memory read, then
// the 128-bit compare. Each bucket head carries its valid bit in the head memory; the
// node pool is filled in order and is never read before it is written. stall is low only
// in idle; a finished result sits in the output register while the next word is taken
// and worked on.
`timescale 1ns / 1ps
`default_nettype none
module kmer_hash_set_chained #(
    parameter int MAX_BUCKETS = khs_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = khs_pkg::POOL_NODES_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [khs_pkg::CFG_W-1:0]    cfg_data,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  khs_pkg::in_word_t            in_word,
    output logic                         out_valid,
    input  wire                          out_stall,
    output khs_pkg::out_word_t           out_word
);
    localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int UW  = $clog2(POOL_NODES + 1);
    localparam int SW  = $clog2(MAX_BUCKETS + 1);
    localparam int RW  = SW + 1;
    localparam int KW  = khs_pkg::KEY_W;
    localparam int CW  = khs_pkg::COUNT_W;

    // memories; a bucket head holds its valid bit on top of the node index
    logic [NW:0]   head_mem [MAX_BUCKETS];
    logic [63:0]   front_mem [POOL_NODES];
    logic [63:0]   back_mem  [POOL_NODES];
    logic [NW-1:0] link_mem  [POOL_NODES];
    logic          link_ok_mem [POOL_NODES];

    khs_pkg::state_t state_reg, state_next;
    logic [CW-1:0]     cfg_reg;
    logic [SW-1:0]     size_eff;
    khs_pkg::in_word_t q_reg;
    logic [KW-1:0]     key_reg, key_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [BW-1:0]     bucket;
    logic [BW-1:0]     clr_reg;
    logic [NW-1:0]     head_rd_reg, link_rd_reg, cur_reg, cur_next;
    logic              head_ok_rd_reg, link_ok_rd_reg;
    logic [63:0]       front_rd_reg, back_rd_reg;
    logic [UW-1:0]     used_reg;
    logic [CW-1:0]     coll_reg;
    logic              out_valid_reg, out_valid_next;
    khs_pkg::out_word_t out_reg, out_next;
    khs_pkg::out_word_t res_reg, res_next;
    logic              do_insert, do_collide, pool_full;
    logic [RW-1:0]     rem_shift;
    logic [UW:0]       steps_reg, steps_next;

    // effective modulus: zero reads as one, saturate at MAX_BUCKETS
    always_comb
    begin
        if (cfg_reg == '0)
            size_eff = SW'(1);
        else if (cfg_reg > CW'(MAX_BUCKETS))
            size_eff = SW'(MAX_BUCKETS);
        else
            size_eff = cfg_reg[SW-1:0];
    end

    assign bucket    = rem_reg[BW-1:0];
    assign pool_full = (used_reg == UW'(POOL_NODES));
    assign rem_shift = {rem_reg[RW-2:0], key_reg[KW-1]};
    assign in_stall  = (state_reg != khs_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= khs_pkg::S_CLEAR;
            clr_reg       <= '0;
            cfg_reg       <= CW'(1024);
            used_reg      <= '0;
            coll_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == khs_pkg::S_CLEAR)
                clr_reg <= clr_reg + BW'(1);
            if (cfg_we)
                cfg_reg <= CW'(cfg_data);
            if (do_insert)
            begin
                used_reg <= used_reg + UW'(1);
                if (do_collide && coll_reg != khs_pkg::COUNT_MAX)
                    coll_reg <= coll_reg + CW'(1);
            end
        end
    end

    // payload and memory ports
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        out_reg        <= out_next;
        res_reg        <= res_next;
        {head_ok_rd_reg, head_rd_reg} <= head_mem[bucket];
        front_rd_reg   <= front_mem[cur_reg];
        back_rd_reg    <= back_mem[cur_reg];
        link_rd_reg    <= link_mem[cur_reg];
        link_ok_rd_reg <= link_ok_mem[cur_reg];
        if (state_reg == khs_pkg::S_IDLE && in_valid && !in_stall)
            q_reg <= in_word;
        if (state_reg == khs_pkg::S_CLEAR)
            head_mem[clr_reg] <= '0;
        else if (do_insert)
            head_mem[bucket] <= {1'b1, used_reg[NW-1:0]};
        if (do_insert)
        begin
            front_mem[used_reg[NW-1:0]] <= q_reg.front_chars;
            back_mem[used_reg[NW-1:0]]  <= q_reg.back_chars;
            link_mem[used_reg[NW-1:0]]  <= head_rd_reg;
            link_ok_mem[used_reg[NW-1:0]] <= head_ok_rd_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        do_insert      = 1'b0;
        do_collide     = 1'b0;
        unique case (state_reg)
            khs_pkg::S_CLEAR:
            begin
                // empty one bucket per cycle, then open the input
                if (clr_reg == BW'(MAX_BUCKETS - 1))
                    state_next = khs_pkg::S_IDLE;
            end
            khs_pkg::S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    key_next   = khs_pkg::fragment_key(in_word.front_chars,
                                                       in_word.back_chars);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = khs_pkg::S_MOD;
                end
            end
            khs_pkg::S_MOD:
            begin
                // restoring step: shift in one key bit, subtract if it fits
                if (rem_shift >= RW'(size_eff))
                    rem_next = rem_shift - RW'(size_eff);
                else
                    rem_next = rem_shift;
                key_next = {key_reg[KW-2:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(KW - 1))
                    state_next = khs_pkg::S_HEAD;
            end
            khs_pkg::S_HEAD:
                state_next = khs_pkg::S_HEADW;
            khs_pkg::S_HEADW:
            begin
                res_next = '0;
                res_next.collision_total = coll_reg;
                if (q_reg.action == khs_pkg::ACT_INSERT)
                begin
                    if (pool_full)
                        res_next.status = khs_pkg::ST_FULL;
                    else
                    begin
                        do_insert  = 1'b1;
                        do_collide = head_ok_rd_reg;
                        res_next.collided = head_ok_rd_reg;
                        if (head_ok_rd_reg && coll_reg != khs_pkg::COUNT_MAX)
                            res_next.collision_total = coll_reg + CW'(1);
                    end
                    state_next = khs_pkg::S_DONE;
                end
                else
                begin
                    cur_next   = head_rd_reg;
                    steps_next = '0;
                    state_next = head_ok_rd_reg ? khs_pkg::S_NODE : khs_pkg::S_DONE;
                end
            end
            khs_pkg::S_NODE:
                state_next = khs_pkg::S_CMP;
            khs_pkg::S_CMP:
            begin
                // compare the node, then follow its link
                if (front_rd_reg == q_reg.front_chars && back_rd_reg == q_reg.back_chars)
                begin
                    res_next.found = 1'b1;
                    state_next = khs_pkg::S_DONE;
                end
                else
                begin
                    cur_next   = link_rd_reg;
                    steps_next = steps_reg + (UW+1)'(1);
                    if (!link_ok_rd_reg || steps_reg + (UW+1)'(1) >= (UW+1)'(POOL_NODES))
                        state_next = khs_pkg::S_DONE;
                    else
                        state_next = khs_pkg::S_NODE;
                end
            end
            khs_pkg::S_DONE:
            begin
                // hand the result over once the output register is free
                if (!(out_valid_reg && out_stall))
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = khs_pkg::S_IDLE;
                end
            end
            default:
                state_next = khs_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### hdl/khs_checker.sv
// khs_checker: port-level assertions for kmer_hash_set_chained.
// Depends on khs_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps
`default_nettype none
module khs_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_stall,
    input khs_pkg::in_word_t   in_word,
    input wire                 out_valid,
    input wire                 out_stall,
    input khs_pkg::out_word_t  out_word
);
    // a word taken blocks input on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while busy");

    // a refused insert never reports a collision or a hit
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.status) |-> (!out_word.collided && !out_word.found))
        else $error("bad full result");

    // found and collided never both set
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_word.found && out_word.collided))
        else $error("found and collided together");

    // held result does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
        else $error("stalled result changed");
endmodule

bind kmer_hash_set_chained khs_checker u_khs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
);
`default_nettype wire

### verif/tb.sv
// tb: self-checking bench for kmer_hash_set_chained (chained hash set of DNA fragments).
// Depends on khs_pkg for the word types and action/status codes, and on kmer_hash_set_chained.
`timescale 1ns / 1ps
module tb;

    localparam int BUCKETS = 1024;
    localparam int POOL    = 4096;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [khs_pkg::CFG_W-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    khs_pkg::in_word_t          in_word = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    khs_pkg::out_word_t         out_word;

    kmer_hash_set_chained dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    initial forever #5 clk = ~clk;

    // Shadow copy of the hash set: bucket heads, node pool, counters, modulus.
    logic [12:0]  shadow_head [BUCKETS];
    bit           shadow_head_ok [BUCKETS];
    logic [63:0]  shadow_front [POOL];
    logic [63:0]  shadow_back [POOL];
    logic [12:0]  shadow_link [POOL];
    bit           shadow_link_ok [POOL];
    int unsigned  shadow_used = 0;
    logic [12:0]  shadow_collisions = '0;
    int unsigned  shadow_size = 1024;

    khs_pkg::in_word_t  pending_words [$];   // words waiting for the driver
    khs_pkg::out_word_t expected_results [$]; // predicted results, oldest first
    khs_pkg::in_word_t  inserted_frags [$];  // fragments inserted so far, for search hits
    int           error_count = 0;
    bit           quiet_mode = 1'b0;   // no idling on either side while set
    bit           long_hold = 1'b0;
    int unsigned  cycle_count = 0;
    int           in_gap = 0;

    // Map one character to its base-4 digit.
    function automatic logic [1:0] char_digit(input logic [7:0] ch);
        if (ch == "A") return 2'd0;
        if (ch == "C") return 2'd1;
        if (ch == "G") return 2'd2;
        return 2'd3;
    endfunction

    // Bucket index of a fragment under the current modulus.
    function automatic int unsigned bucket_index(input logic [63:0] front,
                                                 input logic [63:0] back);
        logic [127:0] chars;
        logic [31:0]  hkey;
        int unsigned  mod;
        chars = {front, back};
        hkey = '0;
        for (int i = 0; i < 16; i++)
            hkey = {hkey[29:0], char_digit(chars[127-8*i -: 8])};
        mod = (shadow_size == 0) ? 1 : (shadow_size > BUCKETS ? BUCKETS : shadow_size);
        return hkey % mod;
    endfunction

    // Apply one accepted word to the shadow set and queue the result it must produce.
    function automatic void predict_lookup(input khs_pkg::in_word_t w);
        khs_pkg::out_word_t r;
        int unsigned b;
        int unsigned cur;
        int unsigned steps;
        bit          ok;
        r = '0;
        b = bucket_index(w.front_chars, w.back_chars);
        if (w.action == khs_pkg::ACT_INSERT) begin
            if (shadow_used >= POOL) begin
                r.status = khs_pkg::ST_FULL;
            end else begin
                shadow_front[shadow_used] = w.front_chars;
                shadow_back[shadow_used] = w.back_chars;
                shadow_link[shadow_used] = shadow_head[b];
                shadow_link_ok[shadow_used] = shadow_head_ok[b];
                if (shadow_head_ok[b]) begin
                    r.collided = 1'b1;
                    if (shadow_collisions != khs_pkg::COUNT_MAX)
                        shadow_collisions = shadow_collisions + 13'd1;
                end
                shadow_head[b] = shadow_used[12:0];
                shadow_head_ok[b] = 1'b1;
                shadow_used++;
            end
        end else begin
            ok = shadow_head_ok[b];
            cur = 32'(shadow_head[b]);
            steps = 0;
            // Walk the chain until a full 16-byte match or the end.
            while (ok && steps < POOL && cur < POOL) begin
                if (shadow_front[cur] == w.front_chars && shadow_back[cur] == w.back_chars)
                begin
                    r.found = 1'b1;
                    break;
                end
                ok = shadow_link_ok[cur];
                cur = 32'(shadow_link[cur]);
                steps++;
            end
        end
        r.collision_total = shadow_collisions;
        expected_results.push_back(r);
    endfunction

    // Idle length: mostly none, some short, a few long.
    function automatic int idle_len();
        int unsigned r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 3) return $urandom_range(20, 80);
        if (r < 30) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Random fragment: mostly A/C/G/T, now and then an arbitrary byte.
    function automatic logic [63:0] random_chars();
        logic [63:0] v;
        logic [7:0]  pick [4];
        pick = '{"A", "C", "G", "T"};
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 9) == 0)
                v[8*i +: 8] = 8'($urandom_range(0, 255));
            else
                v[8*i +: 8] = pick[$urandom_range(0, 3)];
        end
        return v;
    endfunction

    // Queue an insert, keeping the fragment for later search hits.
    task automatic queue_insert(input logic [63:0] front, input logic [63:0] back);
        khs_pkg::in_word_t w;
        w.action = khs_pkg::ACT_INSERT;
        w.front_chars = front;
        w.back_chars = back;
        pending_words.push_back(w);
        inserted_frags.push_back(w);
    endtask

    task automatic queue_search(input logic [63:0] front, input logic [63:0] back);
        khs_pkg::in_word_t w;
        w.action = khs_pkg::ACT_SEARCH;
        w.front_chars = front;
        w.back_chars = back;
        pending_words.push_back(w);
    endtask

    // Random mix: inserts, searches for stored fragments, near misses and noise.
    task automatic queue_random(input int count);
        khs_pkg::in_word_t w;
        int unsigned r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                queue_insert(random_chars(), random_chars());
            end else if (r < 75 && inserted_frags.size() > 0) begin
                w = inserted_frags[$urandom_range(0, inserted_frags.size() - 1)];
                queue_search(w.front_chars, w.back_chars);
            end else if (r < 85 && inserted_frags.size() > 0) begin
                // Near miss: flip one bit of a stored fragment.
                w = inserted_frags[$urandom_range(0, inserted_frags.size() - 1)];
                w.back_chars[$urandom_range(0, 63)] ^= 1'b1;
                queue_search(w.front_chars, w.back_chars);
            end else if (r < 93) begin
                queue_search(random_chars(), random_chars());
            end else begin
                w.action = 1'($urandom_range(0, 1));
                w.front_chars = {$urandom, $urandom};
                w.back_chars = {$urandom, $urandom};
                if (w.action == khs_pkg::ACT_INSERT) queue_insert(w.front_chars, w.back_chars);
                else queue_search(w.front_chars, w.back_chars);
            end
        end
    endtask

    // Hold until every word is taken and every result has come back.
    task automatic drain();
        wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    // Write table_size while the block is idle.
    task automatic write_size(input logic [khs_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_size = 32'(value);
    endtask

    // Driver: present one word at a time, predict on acceptance, advance after a gap.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else if (in_valid && !in_stall) begin
            predict_lookup(in_word);
            in_gap <= idle_len();
            in_valid <= 1'b0;
        end else if (!in_valid) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if (pending_words.size() > 0) begin
                in_word <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted here, so the block backs up and stalls its input.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cycle_count <= 0;
            long_hold <= 1'b0;
        end else begin
            cycle_count <= cycle_count + 1;
            long_hold <= (cycle_count >= 1500 && cycle_count < 2300);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction, then pick the stall.
    always @(posedge clk or negedge rst_n) begin
        khs_pkg::out_word_t e;
        int unsigned r;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word %h", out_word);
                    error_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (out_word.found !== e.found) begin
                        $error("found: expected %0d, got %0d", e.found, out_word.found);
                        error_count++;
                    end
                    if (out_word.collided !== e.collided) begin
                        $error("collided: expected %0d, got %0d",
                               e.collided, out_word.collided);
                        error_count++;
                    end
                    if (out_word.collision_total !== e.collision_total) begin
                        $error("collision_total: expected %0d, got %0d",
                               e.collision_total, out_word.collision_total);
                        error_count++;
                    end
                    if (out_word.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, out_word.status);
                        error_count++;
                    end
                end
            end
            r = $urandom_range(0, 99);
            out_stall <= long_hold || (!quiet_mode && (r < 25 || (r < 27 && out_stall)));
        end
    end

    // Stimulus: directed words, then random phases across table sizes, then a final burst.
    initial begin
        khs_pkg::in_word_t w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes at the reset modulus: zero bytes, all-ones bytes, pure bases.
        queue_search(64'h0, 64'h0);
        queue_insert(64'h0, 64'h0);
        queue_search(64'h0, 64'h0);
        queue_insert(64'h0, 64'h0);                  // duplicate is stored again
        queue_insert({8{8'hFF}}, {8{8'hFF}});
        queue_search({8{8'hFF}}, {8{8'hFF}});
        queue_search({8{8'hFF}}, {{7{8'hFF}}, 8'hFE});
        queue_insert({8{"A"}}, {8{"A"}});
        queue_insert({8{"C"}}, {8{"C"}});
        queue_insert({8{"G"}}, {8{"G"}});
        queue_insert({8{"T"}}, {8{"T"}});
        queue_insert({"C", {7{"A"}}}, {8{"A"}});     // key 2^30: same bucket as all A
        queue_search({8{"A"}}, {8{"A"}});
        queue_search({8{"G"}}, {8{"G"}});
        queue_search({8{"A"}}, {{7{"A"}}, "C"});
        queue_insert(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        queue_search(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        queue_search(64'h0123456789ABCDEF, 64'hFEDCBA9876543211);
        queue_random(300);          // keeps the sender busy through the long hold-off
        drain();

        // Zero size acts as one bucket: every word shares a single chain.
        write_size(0);
        queue_random(60);
        drain();
        write_size(1);
        quiet_mode = 1'b1;
        queue_random(40);
        drain();
        quiet_mode = 1'b0;
        // Oversized value saturates to the full table.
        write_size(11'd2047);
        queue_random(250);
        drain();
        write_size(2);
        queue_random(150);
        drain();
        write_size(11'($urandom_range(3, 1023)));
        queue_random(250);
        drain();
        write_size(1024);
        quiet_mode = 1'b1;
        queue_random(150);
        drain();
        quiet_mode = 1'b0;
        queue_random(350);
        drain();

        // Close with a burst of inserts and searches for stored fragments.
        for (int i = 0; i < 12; i++)
            queue_insert(random_chars(), random_chars());
        for (int i = 0; i < 8; i++) begin
            w = inserted_frags[$urandom_range(0, inserted_frags.size() - 1)];
            queue_search(w.front_chars, w.back_chars);
        end
        drain();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### kmer_hash_set_chained.f
hdl/khs_pkg.sv
hdl/kmer_hash_set_chained.sv
hdl/khs_checker.sv
verif/tb.sv
